// ===== src/wtrgb_pkg.sv =====
// Shared constants, types and elaboration-time table builders for the wavelength to RGB block.
package wtrgb_pkg;

	// Build-time gamma (in hundredths) and intensity fraction width
	localparam int GAMMA_HUNDREDTHS = 80;
	localparam int FRACTION_BITS    = 10;

	// Derived fixed-point sizes
	localparam int UNIT      = 1 << FRACTION_BITS;
	localparam int X_W       = FRACTION_BITS + 1;
	localparam int GAM_DEPTH = UNIT + 1;
	localparam int WL_W      = 10;
	localparam int WL_DEPTH  = 1 << WL_W;
	localparam int Q_FRAC    = 30;

	// Segment edges in nanometres
	localparam int WL_LO        = 380;
	localparam int WL_VIOLET_HI = 440;
	localparam int WL_BLUE_HI   = 490;
	localparam int WL_CYAN_HI   = 510;
	localparam int WL_GREEN_HI  = 580;
	localparam int WL_YELLOW_HI = 645;
	localparam int WL_HI        = 750;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] BYTE_FULL = 8'hFF;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	typedef enum logic [2:0] {
		SEG_BLACK,
		SEG_VIOLET,
		SEG_BLUE,
		SEG_CYAN,
		SEG_GREEN,
		SEG_YELLOW,
		SEG_RED
	} seg_t;

	// One classified item: segment plus up to two intensities for the gamma lookup
	typedef struct packed {
		seg_t             seg;
		logic [X_W-1:0]   xa;
		logic [X_W-1:0]   xb;
	} item_t;

	typedef logic [2*X_W-1:0] int_rom_t [WL_DEPTH];
	typedef logic [7:0] gam_rom_t [GAM_DEPTH];
	typedef longint unsigned root_tab_t [31];

	// Pick the segment; the lower segment wins on a shared edge
	function automatic seg_t classify(input logic [WL_W-1:0] w);
		seg_t s;
		s = SEG_BLACK;
		priority if (w < WL_W'(WL_LO)) begin
			s = SEG_BLACK;
		end else if (w <= WL_W'(WL_VIOLET_HI)) begin
			s = SEG_VIOLET;
		end else if (w <= WL_W'(WL_BLUE_HI)) begin
			s = SEG_BLUE;
		end else if (w <= WL_W'(WL_CYAN_HI)) begin
			s = SEG_CYAN;
		end else if (w <= WL_W'(WL_GREEN_HI)) begin
			s = SEG_GREEN;
		end else if (w <= WL_W'(WL_YELLOW_HI)) begin
			s = SEG_YELLOW;
		end else if (w <= WL_W'(WL_HI)) begin
			s = SEG_RED;
		end else begin
			s = SEG_BLACK;
		end
		return s;
	endfunction

	// Per-wavelength ramp intensities in Q1.FRACTION_BITS
	function automatic int_rom_t build_int_rom();
		int_rom_t         rom;
		seg_t             s;
		longint unsigned  w;
		longint unsigned  d;
		longint unsigned  u;
		longint unsigned  xa;
		longint unsigned  xb;
		u = longint'(UNIT);
		for (int i = 0; i < WL_DEPTH; i++) begin
			s  = classify(WL_W'(i));
			w  = longint'(i);
			xa = 0;
			xb = 0;
			unique case (s)
				SEG_VIOLET: begin
					d  = w - WL_LO;
					xa = u * (60 - d) * (180 + 7 * d) / 36000;
					xb = u * (180 + 7 * d) / 600;
				end
				SEG_BLUE:   xa = u * (w - WL_VIOLET_HI) / 50;
				SEG_CYAN:   xa = u * (WL_CYAN_HI - w) / 20;
				SEG_GREEN:  xa = u * (w - WL_CYAN_HI) / 70;
				SEG_YELLOW: xa = u * (WL_YELLOW_HI - w) / 65;
				SEG_RED:    xa = u * (315 + 7 * (WL_HI - w)) / 1050;
				default: begin
					xa = 0;
					xb = 0;
				end
			endcase
			rom[i] = {X_W'(xa), X_W'(xb)};
		end
		return rom;
	endfunction

	// Integer square root of a 64-bit value
	function automatic longint unsigned isqrt64(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned res;
		longint unsigned b;
		v   = v_in;
		res = 0;
		b   = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > v) b = b >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// Gamma curve in Q1.FRACTION_BITS through log2 and exp2 in Q30
	function automatic longint unsigned gamma_fn(input longint unsigned x,
			input root_tab_t roots);
		longint unsigned one_q;
		longint unsigned m;
		longint unsigned frac;
		longint unsigned mag;
		longint unsigned p;
		longint unsigned k;
		longint unsigned r;
		int              n;
		one_q = 64'd1 << Q_FRAC;
		if (x == 0) return 0;
		if (x >= longint'(UNIT)) return longint'(UNIT);
		n = 0;
		for (int j = 0; j < 40; j++) begin
			if ((x >> (n + 1)) != 0) n = n + 1;
		end
		m    = x << (Q_FRAC - n);
		frac = 0;
		for (int i = 0; i < Q_FRAC; i++) begin
			m    = (m * m) >> Q_FRAC;
			frac = frac << 1;
			if (m >= (one_q << 1)) begin
				m    = m >> 1;
				frac = frac | 64'd1;
			end
		end
		mag = (longint'(FRACTION_BITS - n) << Q_FRAC) - frac;
		p   = (mag * longint'(GAMMA_HUNDREDTHS)) / 100;
		k   = p >> Q_FRAC;
		if (k >= 31) return 0;
		r = one_q;
		for (int i = 1; i <= Q_FRAC; i++) begin
			if (((p >> (Q_FRAC - i)) & 64'd1) != 0) r = (r * roots[i]) >> Q_FRAC;
		end
		r = r >> k;
		return r >> (Q_FRAC - FRACTION_BITS);
	endfunction

	// Intensity to output byte: gamma, times 255, truncate, clamp
	function automatic gam_rom_t build_gam_rom();
		gam_rom_t        rom;
		root_tab_t       roots;
		longint unsigned one_q;
		longint unsigned y;
		longint unsigned v;
		one_q    = 64'd1 << Q_FRAC;
		roots[0] = one_q;
		roots[1] = isqrt64((one_q >> 1) << Q_FRAC);
		for (int i = 2; i <= Q_FRAC; i++) begin
			roots[i] = isqrt64(roots[i-1] << Q_FRAC);
		end
		for (int i = 0; i < GAM_DEPTH; i++) begin
			y = gamma_fn(longint'(i), roots);
			v = (255 * y) >> FRACTION_BITS;
			if (v > 255) v = 255;
			rom[i] = 8'(v);
		end
		return rom;
	endfunction

endpackage

// ===== src/wtrgb_front.sv =====
// Front end: takes items, classifies the segment and looks up ramp intensities.
module wtrgb_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [wtrgb_pkg::WL_W-1:0]   wavelength_nm,
	input  logic                         q_full,
	output logic                         push,
	output wtrgb_pkg::item_t             item
);
	import wtrgb_pkg::*;

	localparam int_rom_t INT_ROM = build_int_rom();

	logic                 accept;
	logic                 valid_s1;
	seg_t                 seg_s1;
	logic [2*X_W-1:0]     x_s1;

	// Hand an item to the queue whenever it has room
	assign push   = valid_s1 && !q_full;
	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;

	// Track the stage-one item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read the intensity table and classify on accept; hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= INT_ROM[wavelength_nm];
			seg_s1 <= classify(wavelength_nm);
		end
	end

	assign item.seg = seg_s1;
	assign item.xa  = x_s1[2*X_W-1:X_W];
	assign item.xb  = x_s1[X_W-1:0];

endmodule

// ===== src/wtrgb_queue.sv =====
// Short queue of classified items between front and back.
module wtrgb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wtrgb_pkg::item_t  push_item,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output wtrgb_pkg::item_t  pop_item
);
	import wtrgb_pkg::*;

	item_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_item = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== src/wtrgb_back.sv =====
// Back end: gamma lookup of the ramped channels and channel steering to the outputs.
module wtrgb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  wtrgb_pkg::item_t  q_item,
	output logic              pop,
	output logic              done,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue
);
	import wtrgb_pkg::*;

	localparam gam_rom_t GAM_ROM = build_gam_rom();

	logic        valid_s2;
	seg_t        seg_s2;
	logic [7:0]  byte_a_s2;
	logic [7:0]  byte_b_s2;
	logic        valid_s3;
	logic [7:0]  red_s3;
	logic [7:0]  green_s3;
	logic [7:0]  blue_s3;
	logic [7:0]  red_d;
	logic [7:0]  green_d;
	logic [7:0]  blue_d;

	// Drain the queue every cycle
	assign pop = q_valid;

	// Advance the valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= q_valid;
			valid_s3 <= valid_s2;
		end
	end

	// Look up both intensities in the gamma table
	always_ff @(posedge clk) begin
		seg_s2    <= q_item.seg;
		byte_a_s2 <= GAM_ROM[q_item.xa];
		byte_b_s2 <= GAM_ROM[q_item.xb];
	end

	// Steer looked-up bytes and fixed levels onto the channels
	always_comb begin
		red_d   = BYTE_ZERO;
		green_d = BYTE_ZERO;
		blue_d  = BYTE_ZERO;
		unique case (seg_s2)
			SEG_VIOLET: begin
				red_d  = byte_a_s2;
				blue_d = byte_b_s2;
			end
			SEG_BLUE: begin
				green_d = byte_a_s2;
				blue_d  = BYTE_FULL;
			end
			SEG_CYAN: begin
				green_d = BYTE_FULL;
				blue_d  = byte_a_s2;
			end
			SEG_GREEN: begin
				red_d   = byte_a_s2;
				green_d = BYTE_FULL;
			end
			SEG_YELLOW: begin
				red_d   = BYTE_FULL;
				green_d = byte_a_s2;
			end
			SEG_RED: begin
				red_d = byte_a_s2;
			end
			default: begin
				red_d   = BYTE_ZERO;
				green_d = BYTE_ZERO;
				blue_d  = BYTE_ZERO;
			end
		endcase
	end

	// Register the colour
	always_ff @(posedge clk) begin
		red_s3   <= red_d;
		green_s3 <= green_d;
		blue_s3  <= blue_d;
	end

	assign done  = valid_s3;
	assign red   = red_s3;
	assign green = green_s3;
	assign blue  = blue_s3;

endmodule

// ===== src/wavelength_to_rgb_color_top.sv =====
// Top level of the wavelength to RGB color block.
//
// Channel   Handshake          Fields
// input     start / busy       wavelength_nm[9:0]
// result    done (strobe)      red[7:0], green[7:0], blue[7:0]
//
// One item is taken per cycle while busy is low. Four register stages sit between input and result:
// intensity table read, queue slot, gamma table read (two read ports) and channel
// steering register. done and the colour come from the last of them.
// Reset clears the valid marks, queue pointers and fill count only; the tables are constant.
// The back end drains the queue every cycle, so busy rises only if the queue fills.
// The receiver cannot stall: done is high for exactly one cycle per item.
module wavelength_to_rgb_color_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [wtrgb_pkg::WL_W-1:0]  wavelength_nm,
	output logic                        done,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue
);
	import wtrgb_pkg::*;

	logic   q_full;
	logic   push;
	item_t  push_item;
	logic   pop;
	logic   q_valid;
	item_t  pop_item;

	wtrgb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.wavelength_nm (wavelength_nm),
		.q_full        (q_full),
		.push          (push),
		.item          (push_item)
	);

	wtrgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	wtrgb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (pop_item),
		.pop     (pop),
		.done    (done),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

	// A result only ever follows a matching item taken at the input
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without a matching item");

	// Out-of-span wavelengths give black
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(wavelength_nm, 4) < WL_W'(WL_LO)
			|| $past(wavelength_nm, 4) > WL_W'(WL_HI)))
		|-> (red == BYTE_ZERO && green == BYTE_ZERO && blue == BYTE_ZERO))
		else $error("out-of-span item not black");

	// Green is checked to be full from the blue edge through the green segment
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(wavelength_nm, 4) >= WL_W'(WL_BLUE_HI)
			&& $past(wavelength_nm, 4) <= WL_W'(WL_GREEN_HI))
		|-> (green == BYTE_FULL))
		else $error("green not full in its plateau");

endmodule
